### rtl/core/tlwbc_pkg.sv
// Shared constants, types and command/status groups of the two-level cache core.
package tlwbc_pkg;

   localparam int BLOCK_BYTES  = 64;
   localparam int L1_LINES     = 256;
   localparam int L2_LINES     = 512;
   localparam int MEMORY_BYTES = 65536;

   localparam int WORD_BITS = 32;
   localparam int BLK_WORDS = BLOCK_BYTES / 4;
   localparam int BLK_BITS  = BLK_WORDS * WORD_BITS;
   localparam int OFF_W     = $clog2(BLK_WORDS);
   localparam int BOFF_W    = $clog2(BLOCK_BYTES);
   localparam int ADDR_W    = $clog2(MEMORY_BYTES);
   localparam int MEM_ROWS  = MEMORY_BYTES / BLOCK_BYTES;
   localparam int ROW_W     = $clog2(MEM_ROWS);
   localparam int L1_IDX_W  = $clog2(L1_LINES);
   localparam int L1_TAG_W  = ROW_W - L1_IDX_W;
   localparam int L2_IDX_W  = $clog2(L2_LINES);
   localparam int L2_TAG_W  = ROW_W - L2_IDX_W;
   localparam int COST_W    = 16;
   localparam int CSR_AW    = 5;

   typedef logic [BLK_BITS-1:0] block_type;

   typedef enum logic [2:0] {
      REG_DRAM_READ  = 3'd0,
      REG_DRAM_WRITE = 3'd1,
      REG_L2_READ    = 3'd2,
      REG_L2_WRITE   = 3'd3,
      REG_L1_READ    = 3'd4,
      REG_L1_WRITE   = 3'd5
   } reg_index_type;

   typedef struct packed {
      logic [COST_W-1:0] dram_read;
      logic [COST_W-1:0] dram_write;
      logic [COST_W-1:0] l2_read;
      logic [COST_W-1:0] l2_write;
      logic [COST_W-1:0] l1_read;
      logic [COST_W-1:0] l1_write;
   } cost_type;

   typedef struct packed {
      logic capture;
      logic l1_look;
      logic l2_issue;
      logic l2_wr;
      logic l2_check;
      logic mem_wb;
      logic mem_rd;
      logic l2_done;
      logic finish;
      logic clear_step;
   } cmd_type;

   typedef struct packed {
      logic clear_done;
      logic err;
      logic l1_hit;
      logic l1_victim_dirty;
      logic l2_hit;
      logic l2_victim_dirty;
      logic out_free;
   } status_type;

endpackage

### rtl/core/two_level_writeback_cache_core.sv
// Top level of the two-level write-back cache core: cost registers and unit hookup.
//
// One word read or write per request, served by a direct-mapped write-back L1 over a
// direct-mapped write-back L2 over a block-wide main memory. An L1 hit goes from the
// request transfer through the L1 lookup to the result register; an L1 miss walks the
// L2 once (issue, check, a memory write-back of a dirty L2 victim, a memory read on an
// L2 miss, done) and twice if the L1 victim is dirty, the first walk writing that victim
// into the L2. The sequencer returns to idle as the result register loads and takes the
// next request there; a full result register holds the access until the result is taken.
// The steps follow from the single-port block memories, each touched with a registered
// read. After reset the core sweeps main memory and the L2 metadata one block row per
// cycle (all 1024 rows) before it takes a request; cost registers can be written at any
// time during that sweep. Addresses at or beyond 64 KiB return status 1 and leave
// everything unchanged.
module two_level_writeback_cache_core import tlwbc_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_kind,
   input  logic [31:0]       req_address,
   input  logic [31:0]       req_write_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [31:0]       rsp_read_data,
   output logic              rsp_status,
   output logic              rsp_l1_hit,
   output logic              rsp_l2_hit,
   output logic [31:0]       rsp_elapsed_time,
   input  logic              psel,
   input  logic              penable,
   input  logic              pwrite,
   input  logic [CSR_AW-1:0] paddr,
   input  logic [31:0]       pwdata,
   output logic [31:0]       prdata,
   output logic              pready
);

   cost_type   cost_ff;
   cmd_type    cmd;
   status_type stat;
   logic [2:0] reg_sel;

   assign pready  = 1'b1;
   assign reg_sel = paddr[CSR_AW-1:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         cost_ff.dram_read  <= 16'd100;
         cost_ff.dram_write <= 16'd50;
         cost_ff.l2_read    <= 16'd10;
         cost_ff.l2_write   <= 16'd5;
         cost_ff.l1_read    <= 16'd1;
         cost_ff.l1_write   <= 16'd1;
      end else if (psel && penable && pwrite) begin
         unique case (reg_sel)
            REG_DRAM_READ:  cost_ff.dram_read  <= pwdata[COST_W-1:0];
            REG_DRAM_WRITE: cost_ff.dram_write <= pwdata[COST_W-1:0];
            REG_L2_READ:    cost_ff.l2_read    <= pwdata[COST_W-1:0];
            REG_L2_WRITE:   cost_ff.l2_write   <= pwdata[COST_W-1:0];
            REG_L1_READ:    cost_ff.l1_read    <= pwdata[COST_W-1:0];
            REG_L1_WRITE:   cost_ff.l1_write   <= pwdata[COST_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         REG_DRAM_READ:  prdata = 32'(cost_ff.dram_read);
         REG_DRAM_WRITE: prdata = 32'(cost_ff.dram_write);
         REG_L2_READ:    prdata = 32'(cost_ff.l2_read);
         REG_L2_WRITE:   prdata = 32'(cost_ff.l2_write);
         REG_L1_READ:    prdata = 32'(cost_ff.l1_read);
         REG_L1_WRITE:   prdata = 32'(cost_ff.l1_write);
         default:        prdata = 32'd0;
      endcase
   end

   tlwbc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   tlwbc_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .cost             (cost_ff),
      .req_kind         (req_kind),
      .req_address      (req_address),
      .req_write_data   (req_write_data),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_read_data    (rsp_read_data),
      .rsp_status       (rsp_status),
      .rsp_l1_hit       (rsp_l1_hit),
      .rsp_l2_hit       (rsp_l2_hit),
      .rsp_elapsed_time (rsp_elapsed_time)
   );

endmodule

### rtl/core/tlwbc_ctrl.sv
// Sequencer of the two-level cache core: steps one access through L1, L2 and memory.
module tlwbc_ctrl import tlwbc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   input  status_type stat,
   output cmd_type    cmd
);

   typedef enum logic [9:0] {
      S_CLEAR    = 10'b0000000001,
      S_IDLE     = 10'b0000000010,
      S_LOOK     = 10'b0000000100,
      S_L2_ISSUE = 10'b0000001000,
      S_L2_CHECK = 10'b0000010000,
      S_MEM_WB   = 10'b0000100000,
      S_MEM_RD   = 10'b0001000000,
      S_L2_DONE  = 10'b0010000000,
      S_FINISH   = 10'b0100000000,
      S_SPARE    = 10'b1000000000
   } state_type;

   state_type state_ff, state_in;
   logic      wr_ff, wr_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         wr_ff    <= 1'b0;
      end else begin
         state_ff <= state_in;
         wr_ff    <= wr_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      wr_in     = wr_ff;
      cmd       = '0;
      cmd.l2_wr = wr_ff;
      req_ready = 1'b0;
      unique case (state_ff)
         S_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (stat.clear_done) state_in = S_IDLE;
         end
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_LOOK;
            end
         end
         S_LOOK: begin
            cmd.l1_look = 1'b1;
            if (stat.err || stat.l1_hit) begin
               state_in = S_FINISH;
            end else begin
               wr_in    = stat.l1_victim_dirty;
               state_in = S_L2_ISSUE;
            end
         end
         S_L2_ISSUE: begin
            cmd.l2_issue = 1'b1;
            state_in     = S_L2_CHECK;
         end
         S_L2_CHECK: begin
            cmd.l2_check = 1'b1;
            if (stat.l2_hit)               state_in = S_L2_DONE;
            else if (stat.l2_victim_dirty) state_in = S_MEM_WB;
            else                           state_in = S_MEM_RD;
         end
         S_MEM_WB: begin
            cmd.mem_wb = 1'b1;
            state_in   = S_MEM_RD;
         end
         S_MEM_RD: begin
            cmd.mem_rd = 1'b1;
            state_in   = S_L2_DONE;
         end
         S_L2_DONE: begin
            cmd.l2_done = 1'b1;
            if (wr_ff) begin
               wr_in    = 1'b0;
               state_in = S_L2_ISSUE;
            end else begin
               state_in = S_FINISH;
            end
         end
         S_FINISH: begin
            if (stat.out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

endmodule

### rtl/core/tlwbc_datapath.sv
// Datapath of the two-level cache core: cache arrays, main memory, time counter, result register.
module tlwbc_datapath import tlwbc_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           stat,
   input  cost_type             cost,
   input  logic                 req_kind,
   input  logic [31:0]          req_address,
   input  logic [31:0]          req_write_data,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output logic [31:0]          rsp_read_data,
   output logic                 rsp_status,
   output logic                 rsp_l1_hit,
   output logic                 rsp_l2_hit,
   output logic [31:0]          rsp_elapsed_time
);

   // memories
   logic [L1_TAG_W-1:0]   l1_tag_mem [L1_LINES];
   block_type             l1_blk_mem [L1_LINES];
   logic [L2_TAG_W+1:0]   l2_meta_mem [L2_LINES];   // {valid, dirty, tag}
   block_type             l2_blk_mem [L2_LINES];
   block_type             main_mem [MEM_ROWS];

   logic [L1_LINES-1:0]   l1_valid_ff, l1_dirty_ff;

   logic                  kind_ff;
   logic                  err_ff;
   logic [ADDR_W-1:0]     addr_ff;
   logic [31:0]           wdata_ff;
   logic [L1_TAG_W-1:0]   l1_tag_q;
   block_type             l1_blk_q;
   logic [L2_TAG_W+1:0]   l2_meta_q;
   block_type             l2_blk_q;
   block_type             mem_q;
   block_type             fill_ff;
   logic [ROW_W-1:0]      l2_row_ff;
   logic                  l1_hit_ff, l2_hit_ff, h2_ff;
   logic [31:0]           time_ff;
   logic [ROW_W-1:0]      clr_ff;

   logic                  rsp_valid_ff;
   logic [31:0]           rsp_data_ff, rsp_time_ff;
   logic                  rsp_status_ff, rsp_l1_ff, rsp_l2_ff;

   logic [OFF_W-1:0]      off;
   logic [ROW_W-1:0]      row;
   logic [L1_IDX_W-1:0]   l1_idx;
   logic [L1_TAG_W-1:0]   l1_tag;
   logic [L2_IDX_W-1:0]   l2_idx;
   logic [L2_TAG_W-1:0]   l2_tag;
   logic                  l1_hit_now, l2_hit_now;
   block_type             l1_src, l1_new, l2_fill;
   logic [ROW_W-1:0]      l2_row_sel;
   logic [31:0]           add_cost;

   assign off    = addr_ff[BOFF_W-1:2];
   assign row    = addr_ff[ADDR_W-1:BOFF_W];
   assign l1_idx = row[L1_IDX_W-1:0];
   assign l1_tag = row[ROW_W-1:L1_IDX_W];
   assign l2_idx = l2_row_ff[L2_IDX_W-1:0];
   assign l2_tag = l2_row_ff[ROW_W-1:L2_IDX_W];

   assign l1_hit_now = l1_valid_ff[l1_idx] && (l1_tag_q == l1_tag);
   assign l2_hit_now = l2_meta_q[L2_TAG_W+1] && (l2_meta_q[L2_TAG_W-1:0] == l2_tag);
   assign l2_row_sel = cmd.l2_wr ? {l1_tag_q, l1_idx} : row;
   assign l2_fill    = l2_hit_ff ? l2_blk_q : mem_q;
   assign l1_src     = l1_hit_ff ? l1_blk_q : fill_ff;

   always_comb begin
      l1_new = l1_src;
      if (kind_ff) l1_new[off*WORD_BITS +: WORD_BITS] = wdata_ff;
   end

   always_comb begin
      stat.clear_done      = &clr_ff;
      stat.err             = err_ff;
      stat.l1_hit          = l1_hit_now;
      stat.l1_victim_dirty = l1_valid_ff[l1_idx] && l1_dirty_ff[l1_idx];
      stat.l2_hit          = l2_hit_now;
      stat.l2_victim_dirty = l2_meta_q[L2_TAG_W+1] && l2_meta_q[L2_TAG_W];
      stat.out_free        = !rsp_valid_ff || rsp_ready;
   end

   // cost charged this cycle
   always_comb begin
      add_cost = '0;
      if (cmd.mem_wb) add_cost = 32'(cost.dram_write);
      if (cmd.mem_rd) add_cost = 32'(cost.dram_read);
      if (cmd.l2_done) add_cost = cmd.l2_wr ? 32'(cost.l2_write) : 32'(cost.l2_read);
      if (cmd.finish && !err_ff)
         add_cost = kind_ff ? 32'(cost.l1_write) : 32'(cost.l1_read);
   end

   // L1 arrays
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         l1_tag_q <= l1_tag_mem[req_address[BOFF_W +: L1_IDX_W]];
         l1_blk_q <= l1_blk_mem[req_address[BOFF_W +: L1_IDX_W]];
      end
      if (cmd.finish && !err_ff) begin
         l1_tag_mem[l1_idx] <= l1_tag;
         l1_blk_mem[l1_idx] <= l1_new;
      end
   end

   // L2 arrays; metadata is wiped by the sweep after reset
   always_ff @(posedge clock) begin
      if (cmd.l2_issue) begin
         l2_meta_q <= l2_meta_mem[l2_row_sel[L2_IDX_W-1:0]];
         l2_blk_q  <= l2_blk_mem[l2_row_sel[L2_IDX_W-1:0]];
      end
      if (cmd.clear_step) begin
         if (clr_ff < ROW_W'(L2_LINES)) l2_meta_mem[clr_ff[L2_IDX_W-1:0]] <= '0;
      end else if (cmd.l2_done) begin
         if (cmd.l2_wr) begin
            l2_meta_mem[l2_idx] <= {1'b1, 1'b1, l2_tag};
            l2_blk_mem[l2_idx]  <= l1_blk_q;
         end else if (!l2_hit_ff) begin
            l2_meta_mem[l2_idx] <= {1'b1, 1'b0, l2_tag};
            l2_blk_mem[l2_idx]  <= mem_q;
         end
      end
   end

   // main memory, one block per row
   always_ff @(posedge clock) begin
      if (cmd.mem_rd) mem_q <= main_mem[l2_row_ff];
      if (cmd.clear_step)
         main_mem[clr_ff] <= '0;
      else if (cmd.mem_wb)
         main_mem[{l2_meta_q[L2_TAG_W-1:0], l2_idx}] <= l2_blk_q;
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         kind_ff  <= req_kind;
         addr_ff  <= req_address[ADDR_W-1:0];
         wdata_ff <= req_write_data;
         err_ff   <= req_address[31:ADDR_W] != '0;
      end
      if (cmd.l1_look) l1_hit_ff <= l1_hit_now;
      if (cmd.l2_issue) l2_row_ff <= l2_row_sel;
      if (cmd.l2_check) l2_hit_ff <= l2_hit_now;
      if (cmd.capture) h2_ff <= 1'b1;
      else if (cmd.l2_done && !cmd.l2_wr) begin
         h2_ff   <= l2_hit_ff;
         fill_ff <= l2_fill;
      end
      if (cmd.finish) begin
         rsp_data_ff   <= (err_ff || kind_ff) ? 32'd0 : l1_src[off*WORD_BITS +: WORD_BITS];
         rsp_status_ff <= err_ff;
         rsp_l1_ff     <= !err_ff && l1_hit_ff;
         rsp_l2_ff     <= !err_ff && h2_ff;
         rsp_time_ff   <= time_ff + add_cost;
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         l1_valid_ff  <= '0;
         l1_dirty_ff  <= '0;
         time_ff      <= '0;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         time_ff <= time_ff + add_cost;
         if (cmd.clear_step && !(&clr_ff)) clr_ff <= clr_ff + 1'b1;
         if (cmd.finish && !err_ff) begin
            l1_valid_ff[l1_idx] <= 1'b1;
            l1_dirty_ff[l1_idx] <= (l1_hit_ff && l1_dirty_ff[l1_idx]) || kind_ff;
         end
         if (cmd.finish)      rsp_valid_ff <= 1'b1;
         else if (rsp_ready)  rsp_valid_ff <= 1'b0;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_read_data    = rsp_data_ff;
   assign rsp_status       = rsp_status_ff;
   assign rsp_l1_hit       = rsp_l1_ff;
   assign rsp_l2_hit       = rsp_l2_ff;
   assign rsp_elapsed_time = rsp_time_ff;

endmodule

### verif/two_level_writeback_cache_core_tb.sv
// Testbench for the two-level write-back cache core: directed and random accesses with a scoreboard.
`timescale 1ns / 100ps

module two_level_writeback_cache_core_tb;
   import tlwbc_pkg::*;

   localparam int MEM_WORDS = MEMORY_BYTES / 4;
   localparam int STALL_LIMIT = 20000;

   logic clock = 0;
   logic reset = 1;
   logic req_valid = 0, req_kind = 0;
   logic req_ready;
   logic [31:0] req_address = 0, req_write_data = 0;
   logic rsp_valid, rsp_ready = 0;
   logic [31:0] rsp_read_data, rsp_elapsed_time;
   logic rsp_status, rsp_l1_hit, rsp_l2_hit;
   logic psel = 0, penable = 0, pwrite = 0;
   logic [CSR_AW-1:0] paddr = 0;
   logic [31:0] pwdata = 0;
   logic [31:0] prdata;
   logic pready;

   two_level_writeback_cache_core dut (.*);

   always begin
      #4 clock = 1;
      #4 clock = 0;
   end

   typedef struct packed {
      logic [31:0] read_data;
      logic        status;
      logic        l1_hit;
      logic        l2_hit;
      logic [31:0] elapsed_time;
   } access_result_type;

   // Predictor state
   logic [15:0] cost [6];
   logic        m1_valid [L1_LINES];
   logic        m1_dirty [L1_LINES];
   logic [31:0] m1_tag [L1_LINES];
   block_type   m1_data [L1_LINES];
   logic        m2_valid [L2_LINES];
   logic        m2_dirty [L2_LINES];
   logic [31:0] m2_tag [L2_LINES];
   block_type   m2_data [L2_LINES];
   logic [31:0] memory_words [MEM_WORDS];
   logic [31:0] clock_count;

   access_result_type expected_results [$];
   int errors = 0;
   int results_seen = 0;
   int reads_done = 0, writes_done = 0, range_errors = 0;
   int idle_cycles = 0;
   bit idling_on = 1;

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      errors++;
      $display("mismatch #%0d in %s: got %h expected %h", results_seen, what, got, want);
   endtask

   function automatic void memory_block(input logic [31:0] base, inout block_type blk,
                                        input bit wr);
      int w0;
      w0 = int'(base / 4);
      for (int i = 0; i < BLK_WORDS; i++) begin
         if (wr) memory_words[(w0 + i) % MEM_WORDS] = blk[i*32 +: 32];
         else blk[i*32 +: 32] = memory_words[(w0 + i) % MEM_WORDS];
      end
      clock_count += wr ? 32'(cost[REG_DRAM_WRITE]) : 32'(cost[REG_DRAM_READ]);
   endfunction

   function automatic bit l2_block_move(input logic [31:0] base, inout block_type blk,
                                        input bit wr);
      logic [31:0] tg, ix;
      bit hit;
      tg = base / (L2_LINES * BLOCK_BYTES);
      ix = (base / BLOCK_BYTES) % L2_LINES;
      hit = m2_valid[ix] && m2_tag[ix] == tg;
      if (!hit) begin
         if (m2_valid[ix] && m2_dirty[ix])
            memory_block(m2_tag[ix] * L2_LINES * BLOCK_BYTES + ix * BLOCK_BYTES,
                         m2_data[ix], 1'b1);
         memory_block(base, m2_data[ix], 1'b0);
         m2_valid[ix] = 1'b1;
         m2_dirty[ix] = 1'b0;
         m2_tag[ix] = tg;
      end
      if (wr) begin
         m2_data[ix] = blk;
         m2_dirty[ix] = 1'b1;
         clock_count += 32'(cost[REG_L2_WRITE]);
      end else begin
         blk = m2_data[ix];
         clock_count += 32'(cost[REG_L2_READ]);
      end
      return hit;
   endfunction

   function automatic access_result_type predict_access(input bit wr, input logic [31:0] a_in,
                                                         input logic [31:0] data);
      access_result_type r;
      logic [31:0] a, tg, ix, off;
      bit h1, h2;
      a = a_in & ~32'd3;
      r = '0;
      if (a >= MEMORY_BYTES) begin
         r.status = 1'b1;
         r.elapsed_time = clock_count;
         return r;
      end
      h2 = 1'b1;
      tg = a / (L1_LINES * BLOCK_BYTES);
      ix = (a / BLOCK_BYTES) % L1_LINES;
      off = (a % BLOCK_BYTES) / 4;
      h1 = m1_valid[ix] && m1_tag[ix] == tg;
      if (!h1) begin
         if (m1_valid[ix] && m1_dirty[ix])
            void'(l2_block_move(m1_tag[ix] * L1_LINES * BLOCK_BYTES + ix * BLOCK_BYTES,
                                m1_data[ix], 1'b1));
         h2 = l2_block_move(a - a % BLOCK_BYTES, m1_data[ix], 1'b0);
         m1_valid[ix] = 1'b1;
         m1_dirty[ix] = 1'b0;
         m1_tag[ix] = tg;
      end
      if (wr) begin
         m1_data[ix][off*32 +: 32] = data;
         m1_dirty[ix] = 1'b1;
         clock_count += 32'(cost[REG_L1_WRITE]);
      end else begin
         r.read_data = m1_data[ix][off*32 +: 32];
         clock_count += 32'(cost[REG_L1_READ]);
      end
      r.l1_hit = h1;
      r.l2_hit = h2;
      r.elapsed_time = clock_count;
      return r;
   endfunction

   // valid drops only when a gap follows, so it never gets two assignments in one step
   task automatic random_idle();
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
   endtask

   task automatic send_access(input bit wr, input logic [31:0] a, input logic [31:0] data);
      random_idle();
      req_valid <= 1;
      req_kind <= wr;
      req_address <= a;
      req_write_data <= data;
      do @(posedge clock); while (!req_ready);
      expected_results.push_back(predict_access(wr, a, data));
      if (a >= MEMORY_BYTES) range_errors++;
      else if (wr) writes_done++;
      else reads_done++;
   endtask

   task automatic csr_write(input reg_index_type idx, input logic [31:0] value);
      psel <= 1; penable <= 0; pwrite <= 1;
      paddr <= CSR_AW'(4 * idx); pwdata <= value;
      @(posedge clock);
      penable <= 1;
      do @(posedge clock); while (!pready);
      cost[idx] = value[15:0];
      psel <= 0; penable <= 0; pwrite <= 0;
   endtask

   task automatic wait_drained();
      req_valid <= 0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   task automatic set_costs(input logic [15:0] c0, c1, c2, c3, c4, c5);
      wait_drained();
      csr_write(REG_DRAM_READ, 32'(c0));
      csr_write(REG_DRAM_WRITE, 32'(c1));
      csr_write(REG_L2_READ, 32'(c2));
      csr_write(REG_L2_WRITE, 32'(c3));
      csr_write(REG_L1_READ, 32'(c4));
      csr_write(REG_L1_WRITE, 32'(c5));
   endtask

   // Random addresses; some share L1 index 0 with varied tags, to force dirty victims at both levels
   function automatic logic [31:0] pick_address();
      logic [31:0] a;
      case ($urandom_range(0, 9))
         0: a = $urandom();
         1, 2: a = {16'd0, 2'($urandom_range(0, 3)), 14'd0} | ($urandom() & 32'h3c);
         default: a = $urandom() & (MEMORY_BYTES - 1);
      endcase
      if ($urandom_range(0, 15) == 0) a = a | 32'h3;
      return a;
   endfunction

   task automatic test_directed();
      send_access(0, 32'h0, 32'h0);
      send_access(1, 32'h0, 32'hffff_ffff);
      send_access(0, 32'h3, 32'h0);
      send_access(1, 32'h0000_fffc, 32'ha5a5_5a5a);
      send_access(0, 32'h0000_ffff, 32'h0);
      send_access(1, 32'h0001_0000, 32'h1234_5678);
      send_access(0, 32'hffff_ffff, 32'hffff_ffff);
      send_access(1, 32'h0000_4000, 32'h0bad_f00d);
      send_access(1, 32'h0000_8000, 32'hcafe_babe);
      send_access(1, 32'h0000_c000, 32'h5555_aaaa);
      send_access(0, 32'h0000_0000, 32'h0);
      send_access(0, 32'h0000_4000, 32'h0);
      send_access(0, 32'h0000_8004, 32'h0);
      send_access(0, 32'h0000_8000, 32'h0);
      send_access(0, 32'h0000_c000, 32'h0);
      send_access(1, 32'h0000_103c, 32'h8000_0001);
      send_access(0, 32'h0000_103c, 32'h0);
   endtask

   task automatic test_random(input int count);
      idling_on = 1;
      for (int i = 0; i < count; i++) begin
         if (i > count * 4 / 5) idling_on = 0;
         send_access(1'($urandom_range(0, 1)), pick_address(), $urandom());
      end
   endtask

   task automatic test_cost_extremes();
      set_costs(16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff, 16'hffff);
      test_random(150);
      set_costs(16'd0, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
      test_random(100);
      set_costs(16'($urandom()), 16'($urandom()), 16'($urandom()), 16'($urandom()),
                16'($urandom()), 16'($urandom()));
      test_random(100);
   endtask

   // Result checking against the oldest expectation
   always @(posedge clock) begin
      access_result_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            results_seen++;
            if (expected_results.size() == 0) begin
               errors++;
               $display("unexpected result transfer #%0d", results_seen);
            end else begin
               want = expected_results.pop_front();
               if (rsp_read_data !== want.read_data)
                  report_mismatch("read_data", rsp_read_data, want.read_data);
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_l1_hit !== want.l1_hit)
                  report_mismatch("l1_hit", 32'(rsp_l1_hit), 32'(want.l1_hit));
               if (rsp_l2_hit !== want.l2_hit)
                  report_mismatch("l2_hit", 32'(rsp_l2_hit), 32'(want.l2_hit));
               if (rsp_elapsed_time !== want.elapsed_time)
                  report_mismatch("elapsed_time", rsp_elapsed_time, want.elapsed_time);
            end
         end
      end
   end

   // Receiver stall bursts
   initial begin
      int n;
      forever begin
         @(posedge clock);
         if (idling_on && $urandom_range(0, 7) == 0) begin
            n = $urandom_range(1, 19);
            rsp_ready <= 0;
            repeat (n) @(posedge clock);
         end
         rsp_ready <= 1;
      end
   end

   // Watchdog: no transfer for too long (covers the clearing pass after reset)
   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles > STALL_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      cost[REG_DRAM_READ] = 100; cost[REG_DRAM_WRITE] = 50;
      cost[REG_L2_READ] = 10;    cost[REG_L2_WRITE] = 5;
      cost[REG_L1_READ] = 1;     cost[REG_L1_WRITE] = 1;
      for (int i = 0; i < L1_LINES; i++) begin
         m1_valid[i] = 1'b0; m1_dirty[i] = 1'b0; m1_tag[i] = '0; m1_data[i] = '0;
      end
      for (int i = 0; i < L2_LINES; i++) begin
         m2_valid[i] = 1'b0; m2_dirty[i] = 1'b0; m2_tag[i] = '0; m2_data[i] = '0;
      end
      for (int i = 0; i < MEM_WORDS; i++) memory_words[i] = '0;
      clock_count = 0;
      repeat (2) @(posedge clock);
      reset <= 0;
      @(posedge clock);
      test_directed();
      test_random(680);
      test_cost_extremes();
      wait_drained();
      $display("covered %0d reads, %0d writes, %0d out-of-range accesses, %0d results",
               reads_done, writes_done, range_errors, results_seen);
      $display("cost settings: reset, all-max, all-zero, random");
      if (errors == 0 && expected_results.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule

### sim.f
rtl/core/tlwbc_pkg.sv
rtl/core/tlwbc_ctrl.sv
rtl/core/tlwbc_datapath.sv
rtl/core/two_level_writeback_cache_core.sv
verif/two_level_writeback_cache_core_tb.sv
